// ===== design/assert_macros.svh =====
// Assertion macros shared by the deque RTL.
// Relies on the including module having signals named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every edge outside reset.
`define DQ_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
// When ante holds, cons must hold in the next cycle.
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DQ_ASSERT(label, cond, msg)
`define DQ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== design/dq_pkg.sv =====
// Shared types and codes for the double-ended queue.
// No dependencies.
package dq_pkg;

   localparam int WORD_W        = 32;
   localparam int MODE_W        = 3;
   localparam int STATUS_W      = 3;
   localparam int DEPTH_DEFAULT = 16;

   // request modes
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LIST       = 3'd4;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_ADDED   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_REMOVED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_LISTED  = 3'd4;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_POP,
      OP_LIST
   } op_type;

   // decoded command handed from the front end to the back end
   typedef struct packed {
      op_type                    op;
      logic                      at_front;
      logic signed [WORD_W-1:0]  value;
   } cmd_type;

endpackage

// ===== design/dq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/dq_front.sv =====
// Front end: accepts request words, decodes the mode, queues commands.
// Depends on dq_pkg.
module dq_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [dq_pkg::MODE_W-1:0]   req_mode,
   input  logic signed [dq_pkg::WORD_W-1:0] req_value,
   output logic                        cmd_valid,
   input  logic                        cmd_ready,
   output dq_pkg::cmd_type             cmd
);
   import dq_pkg::*;

   localparam int Q_DEPTH = 2;
   localparam int Q_IDX_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   cmd_type              q_ff [Q_DEPTH];
   logic [Q_IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   fill_ff, fill_in;
   cmd_type              dec;
   logic                 dec_keep;
   logic                 push;
   logic                 pop;

   // mode decode; unused modes are taken and dropped
   always_comb begin
      dec.op       = OP_PUSH;
      dec.at_front = 1'b0;
      dec.value    = req_value;
      dec_keep     = 1'b1;
      case (req_mode)
         MODE_PUSH_FRONT: begin
            dec.op       = OP_PUSH;
            dec.at_front = 1'b1;
         end
         MODE_PUSH_BACK: begin
            dec.op = OP_PUSH;
         end
         MODE_POP_FRONT: begin
            dec.op       = OP_POP;
            dec.at_front = 1'b1;
         end
         MODE_POP_BACK: begin
            dec.op = OP_POP;
         end
         MODE_LIST: begin
            dec.op = OP_LIST;
         end
         default: begin
            dec_keep = 1'b0;
         end
      endcase
   end

   assign req_ready = (fill_ff != Q_CNT_W'(Q_DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready && dec_keep;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// ===== design/dq_back.sv =====
// Back end: ring pointers, entry storage and the response register.
// Depends on dq_pkg, dq_ram and assert_macros.svh.
`include "assert_macros.svh"
module dq_back #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   output logic                             cmd_ready,
   input  dq_pkg::cmd_type                  cmd,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [dq_pkg::WORD_W-1:0] rsp_value_res,
   output logic [dq_pkg::STATUS_W-1:0]      rsp_status,
   output logic                             rsp_last
);
   import dq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = $clog2(2 * DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_DATA
   } state_type;

   state_type                  state_ff, state_in;
   logic [IDX_W-1:0]           front_ff, front_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [IDX_W-1:0]           addr_ff, addr_in;
   logic [CNT_W-1:0]           offset_ff, offset_in;
   logic                       list_ff, list_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       out_free;
   logic                       is_full;
   logic                       is_empty;
   logic                       final_elem;
   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr;
   logic [WORD_W-1:0]          rd_data;

   // (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
   function automatic logic [IDX_W-1:0] ring_add(logic [IDX_W-1:0] base,
                                                 logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] s;
      s = SUM_W'(base) + SUM_W'(off);
      if (s >= SUM_W'(DEPTH)) begin
         s = s - SUM_W'(DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   dq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd.value),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign is_full    = (count_ff == CNT_W'(DEPTH));
   assign is_empty   = (count_ff == '0);
   assign final_elem = !list_ff || ((offset_ff + 1'b1) == count_ff);

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      offset_in     = offset_ff;
      list_in       = list_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      cmd_ready     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = ring_add(front_ff, count_ff);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_ready    = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_value_in = '0;
               case (cmd.op)
                  OP_PUSH: begin
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        wr_en = 1'b1;
                        if (cmd.at_front) begin
                           front_in = ring_add(front_ff, CNT_W'(DEPTH - 1));
                           wr_addr  = front_in;
                        end
                        count_in      = count_ff + 1'b1;
                        rsp_value_in  = cmd.value;
                        rsp_status_in = STATUS_ADDED;
                     end
                  end
                  OP_POP: begin
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = rsp_valid_ff && !rsp_ready;
                        list_in      = 1'b0;
                        if (cmd.at_front) begin
                           addr_in  = front_ff;
                           front_in = ring_add(front_ff, CNT_W'(1));
                        end else begin
                           addr_in = ring_add(front_ff, count_ff - 1'b1);
                        end
                        count_in = count_ff - 1'b1;
                        state_in = S_FETCH;
                     end
                  end
                  OP_LIST: begin
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = rsp_valid_ff && !rsp_ready;
                        list_in      = 1'b1;
                        addr_in      = front_ff;
                        offset_in    = '0;
                        state_in     = S_FETCH;
                     end
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_ready;
                  end
               endcase
            end
         end
         S_FETCH: begin
            state_in = S_DATA;
         end
         S_DATA: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = $signed(rd_data);
               rsp_status_in = list_ff ? STATUS_LISTED : STATUS_REMOVED;
               rsp_last_in   = final_elem;
               if (final_elem) begin
                  state_in = S_IDLE;
               end else begin
                  offset_in = offset_ff + 1'b1;
                  addr_in   = ring_add(addr_ff, CNT_W'(1));
                  state_in  = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         front_ff      <= front_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         addr_ff       <= addr_in;
         offset_ff     <= offset_in;
         list_ff       <= list_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

   `DQ_ASSERT(a_count_bound, count_ff <= CNT_W'(DEPTH), "occupancy above depth")
   `DQ_ASSERT(a_front_bound, {1'b0, front_ff} < (IDX_W + 1)'(DEPTH), "front index out of ring")
   `DQ_ASSERT_NEXT(a_count_held, state_ff != S_IDLE, count_ff == $past(count_ff), "occupancy moved mid read")
   `DQ_ASSERT_NEXT(a_push_grows, cmd_valid && cmd_ready && cmd.op == OP_PUSH && !is_full, count_ff == $past(count_ff) + 1'b1, "push did not grow occupancy")
   `DQ_ASSERT_NEXT(a_push_answers, cmd_valid && cmd_ready && cmd.op == OP_PUSH, rsp_valid_ff, "push gave no word")

endmodule

// ===== design/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit words held in a DEPTH-entry ring.
// Push / full / empty word: goes through the front queue and the response register;
//   one per cycle while rsp does not stall. Pop: S_FETCH issues the registered RAM
//   read and S_DATA puts the removed word in the response register; the back end
//   takes no new command until back in S_IDLE; a list repeats S_FETCH, S_DATA per word.
// Synchronous active-high reset empties the deque; ring contents are not cleared.

// Structure:
//   dq_front - takes request words at once, decodes the mode (unused modes are
//              dropped with no response) and parks commands in a two-entry queue.
//   dq_back  - owns front index, occupancy and the ring RAM; runs each command,
//              walks the ring for pops and lists, and holds the response in a
//              register. While rsp stalls the back end waits; the two-entry queue
//              absorbs up to two more requests before req_ready drops.
// Depends on dq_pkg, dq_front, dq_back, dq_ram.
module double_ended_queue #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [dq_pkg::MODE_W-1:0]        req_mode,
   input  logic signed [dq_pkg::WORD_W-1:0] req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [dq_pkg::WORD_W-1:0] rsp_value_res,
   output logic [dq_pkg::STATUS_W-1:0]      rsp_status,
   output logic                             rsp_last
);
   import dq_pkg::*;

   // decoded command channel between the two halves
   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   dq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .req_value (req_value),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   // rsp_last marks the final word of a request (always set outside a list)
   dq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .cmd           (cmd),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_res (rsp_value_res),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== tb/sv/double_ended_queue_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue: directed rows, then random traffic.
// Needs dq_pkg and the deque RTL.
module double_ended_queue_tb;
   import dq_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   // Worst case per request is a full list: 16 words, every word behind a long
   // response stall, plus a long request gap; the limit allows about 430 such
   // requests with five times margin.
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int DRAIN_CYCLES  = 48;   // list spacing and pop read latency, with margin
   localparam int RANDOM_COUNT  = 400;
   localparam int DIRECTED_ROWS = 14;
   // Mode codes the block drops without a response.
   localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic [STATUS_W-1:0]      status;
      logic                     last;
   } deque_word_type;

   // One directed row; reps > 1 repeats the row with the value stepped by one.
   // typed rows carry the single expected word inline (last is always 1).
   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic signed [WORD_W-1:0] value;
      logic [4:0]               reps;
      logic                     typed;
      logic signed [WORD_W-1:0] exp_value;
      logic [STATUS_W-1:0]      exp_status;
   } row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [MODE_W-1:0]         req_mode = '0;
   logic signed [WORD_W-1:0]  req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [WORD_W-1:0]  rsp_value_res;
   logic [STATUS_W-1:0]       rsp_status;
   logic                      rsp_last;

   // Shadow deque: ring, front slot and fill count.
   logic signed [WORD_W-1:0]  ring [DEPTH];
   int                        front_slot;
   int                        fill;

   deque_word_type            predicted [$];
   deque_word_type            pending_words [$];
   row_type                   directed_rows [DIRECTED_ROWS];

   int                        mismatches = 0;
   int                        words_checked = 0;
   int                        requests_sent = 0;
   int                        lists_sent = 0;
   int                        full_seen = 0;
   int                        empty_seen = 0;
   int                        cycles = 0;
   bit                        steady = 1'b0;   // no idling on either side while set
   int                        rsp_hold = 0;

   double_ended_queue #(.DEPTH(DEPTH)) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_res (rsp_value_res),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still pending", cycles,
                  pending_words.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   task automatic report(input string field, input logic [WORD_W-1:0] got,
                         input logic [WORD_W-1:0] want);
      $display("%0t mismatch on %s: got %h, expected %h (word %0d)", $realtime, field,
               got, want, words_checked);
      mismatches++;
   endtask

   // Shadow deque update for one accepted request; fills predicted with the
   // words the request should produce.
   function automatic void deque_apply(input logic [MODE_W-1:0] mode,
                                       input logic signed [WORD_W-1:0] value);
      int slot;
      predicted.delete();
      case (mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (fill >= DEPTH) begin
               predicted.push_back('{'0, STATUS_FULL, 1'b1});
               full_seen++;
            end else begin
               if (mode == MODE_PUSH_FRONT) begin
                  front_slot = (front_slot + DEPTH - 1) % DEPTH;
                  slot = front_slot;
               end else begin
                  slot = (front_slot + fill) % DEPTH;
               end
               ring[slot] = value;
               fill++;
               predicted.push_back('{value, STATUS_ADDED, 1'b1});
            end
         end
         MODE_POP_FRONT, MODE_POP_BACK: begin
            if (fill == 0) begin
               predicted.push_back('{'0, STATUS_EMPTY, 1'b1});
               empty_seen++;
            end else begin
               if (mode == MODE_POP_FRONT) begin
                  slot = front_slot;
                  front_slot = (front_slot + 1) % DEPTH;
               end else begin
                  slot = (front_slot + fill - 1) % DEPTH;
               end
               fill--;
               predicted.push_back('{ring[slot], STATUS_REMOVED, 1'b1});
            end
         end
         MODE_LIST: begin
            if (fill == 0) begin
               predicted.push_back('{'0, STATUS_EMPTY, 1'b1});
               empty_seen++;
            end else begin
               for (int i = 0; i < fill; i++)
                  predicted.push_back('{ring[(front_slot + i) % DEPTH], STATUS_LISTED,
                                        logic'(i == fill - 1)});
            end
         end
         default: ;   // unused mode: no response
      endcase
   endfunction

   // Drive one request word at the falling edge, hold it until accepted, then
   // queue what it should return (inline expectation for typed rows).
   task automatic issue(input logic [MODE_W-1:0] mode, input logic signed [WORD_W-1:0] value,
                        input bit typed, input deque_word_type want);
      int gap;
      gap = steady ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      deque_apply(mode, value);
      if (typed)
         pending_words.push_back(want);
      else
         foreach (predicted[i]) pending_words.push_back(predicted[i]);
      requests_sent++;
      if (mode == MODE_LIST)
         lists_sent++;
   endtask

   // Response side back-pressure: random stalls, none while steady.
   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= pick_gap();
      end else begin
         rsp_ready <= 1'b1;
         rsp_hold  <= $urandom_range(0, 6);
      end
   end

   // Response checker: each accepted word against the oldest expectation.
   always @(posedge clock) begin
      deque_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            report("unexpected word", rsp_value_res, '0);
         end else begin
            want = pending_words.pop_front();
            if (rsp_value_res !== want.value)
               report("value_res", rsp_value_res, want.value);
            if (rsp_status !== want.status)
               report("status", WORD_W'(rsp_status), WORD_W'(want.status));
            if (rsp_last !== want.last)
               report("last", WORD_W'(rsp_last), WORD_W'(want.last));
         end
         words_checked++;
      end
   end

   initial begin
      row_type                  row;
      deque_word_type           want;
      logic [MODE_W-1:0]        mode;
      logic signed [WORD_W-1:0] value;
      int                       random_done;
      int                       push_weight;
      int                       r;

      foreach (ring[i]) ring[i] = '0;
      front_slot = 0;
      fill       = 0;

      // Empty ops, extreme words, a dropped mode, fill to capacity from both
      // ends, pushes into a full deque, a full list, then a pop from each end.
      directed_rows = '{
         '{MODE_POP_FRONT,  32'sh0,         5'd1, 1'b1, 32'sh0,         STATUS_EMPTY},
         '{MODE_POP_BACK,   32'sh0,         5'd1, 1'b1, 32'sh0,         STATUS_EMPTY},
         '{MODE_LIST,       32'sh0,         5'd1, 1'b1, 32'sh0,         STATUS_EMPTY},
         '{MODE_PUSH_FRONT, 32'sh8000_0000, 5'd1, 1'b1, 32'sh8000_0000, STATUS_ADDED},
         '{MODE_PUSH_BACK,  32'sh7fff_ffff, 5'd1, 1'b1, 32'sh7fff_ffff, STATUS_ADDED},
         '{MODE_LIST,       32'sh0,         5'd1, 1'b0, 32'sh0,         STATUS_LISTED},
         '{MODE_UNUSED_LO,  32'sh5555_aaaa, 5'd1, 1'b0, 32'sh0,         STATUS_EMPTY},
         '{MODE_PUSH_FRONT, 32'sh0000_0100, 5'd7, 1'b0, 32'sh0,         STATUS_ADDED},
         '{MODE_PUSH_BACK,  32'shffff_ff00, 5'd7, 1'b0, 32'sh0,         STATUS_ADDED},
         '{MODE_PUSH_FRONT, 32'sh1234_5678, 5'd1, 1'b1, 32'sh0,         STATUS_FULL},
         '{MODE_PUSH_BACK,  32'sh8765_4321, 5'd1, 1'b1, 32'sh0,         STATUS_FULL},
         '{MODE_LIST,       32'sh0,         5'd1, 1'b0, 32'sh0,         STATUS_LISTED},
         '{MODE_POP_FRONT,  32'sh0,         5'd1, 1'b0, 32'sh0,         STATUS_REMOVED},
         '{MODE_POP_BACK,   32'sh0,         5'd1, 1'b0, 32'sh0,         STATUS_REMOVED}
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part.
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         for (int k = 0; k < row.reps; k++) begin
            want = '{row.exp_value, row.exp_status, 1'b1};
            issue(row.mode, row.value + k, row.typed, want);
         end
      end

      // Random part: the push weight drifts every 40 requests so the deque
      // swings between empty and full; some windows run with no idling.
      random_done = 0;
      push_weight = 50;
      while (random_done < RANDOM_COUNT) begin
         if (random_done % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       push_weight = 80;
               1:       push_weight = 20;
               default: push_weight = 50;
            endcase
            steady = ($urandom_range(0, 3) == 0);
         end
         r = $urandom_range(0, 99);
         if (r < 3)
            mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
         else if (r < 13)
            mode = MODE_LIST;
         else if ($urandom_range(0, 99) < push_weight)
            mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
         else
            mode = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
         case ($urandom_range(0, 19))
            0:       value = 32'sh8000_0000;
            1:       value = 32'sh7fff_ffff;
            2:       value = -32'sd1;
            3:       value = 32'sh0;
            default: value = $urandom;
         endcase
         issue(mode, value, 1'b0, '0);
         if (mode <= MODE_LIST)
            random_done++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      steady = 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d lists, %0d into a full deque, %0d on empty)",
               requests_sent, lists_sent, full_seen, empty_seen);
      $display("Checked %0d response words, %0d mismatches", words_checked, mismatches);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
